FILE: hw/rtl/clsr_pkg.sv
// ----------------------------------------------------------------------------
// clsr_pkg: shared types and constants of the LRU / SRRIP replacement engine
// Sizes of the set/way store, operation codes, configuration register
// indexes, and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package clsr_pkg;

	localparam int SET_COUNT = 64;
	localparam int WAY_COUNT = 8;
	localparam int SET_W     = $clog2(SET_COUNT);
	localparam int WAY_W     = $clog2(WAY_COUNT);
	localparam int WAYS_N_W  = $clog2(WAY_COUNT + 1);
	localparam int STAMP_W   = 64;
	localparam int FUNC_W    = 2;

	// configuration register widths and indexes
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 7;
	localparam int RRPV_CFG_W   = 7;
	localparam int WAYS_CFG_W   = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_POLICY     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RRPV_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

	// operation codes
	typedef enum logic [FUNC_W-1:0] {
		FN_HIT    = 2'd0,
		FN_FILL   = 2'd1,
		FN_VICTIM = 2'd2
	} func_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_TOUCH,
		ST_SCAN,
		ST_AGE,
		ST_WB,
		ST_DONE
	} state_t;

	// one set of the store: valid bits and per-way stamp / RRPV
	typedef struct packed {
		logic [WAY_COUNT-1:0]              valid;
		logic [WAY_COUNT-1:0][STAMP_W-1:0] stamp;
	} row_t;

	// decoded configuration
	typedef struct packed {
		logic                srrip;
		logic [STAMP_W-1:0]  rrpv_max;
		logic [STAMP_W-1:0]  rrpv_fill;
		logic [WAYS_N_W-1:0] ways;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic rd;
		logic touch;
		logic scan;
		logic age;
		logic wb;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		func_t func;
		logic  scan_last;
	} sts_t;

endpackage

FILE: hw/rtl/clsr_ctrl.sv
// ----------------------------------------------------------------------------
// clsr_ctrl: operation sequencer of the replacement engine
// Accepts one operation at a time, steps the datapath through row read,
// update or way scan, write-back, and hands the result to the output register.
// ----------------------------------------------------------------------------
module clsr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  clsr_pkg::sts_t  sts,
	input  logic            out_free,
	output clsr_pkg::cmd_t  cmd,
	output logic            res_load
);
	import clsr_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		res_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_RD;
				end
			end
			ST_RD: begin
				cmd.rd = 1'b1;
				unique case (sts.func) inside
					FN_HIT, FN_FILL: state_d = ST_TOUCH;
					FN_VICTIM:       state_d = ST_SCAN;
					default:         state_d = ST_DONE;
				endcase
			end
			ST_TOUCH: begin
				cmd.touch = 1'b1;
				state_d   = ST_DONE;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_AGE;
				end
			end
			ST_AGE: begin
				cmd.age = 1'b1;
				state_d = ST_WB;
			end
			ST_WB: begin
				cmd.wb  = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: hw/rtl/clsr_dp.sv
// ----------------------------------------------------------------------------
// clsr_dp: datapath of the replacement engine
// Holds the per-set row memory, the access counter and the way scan unit
// that finds invalid, LRU, stale and top-RRPV ways one way per cycle.
// ----------------------------------------------------------------------------
module clsr_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  clsr_pkg::cmd_t              cmd,
	output clsr_pkg::sts_t              sts,
	input  clsr_pkg::cfg_t              cfg,
	input  logic [clsr_pkg::FUNC_W-1:0] in_func,
	input  logic [clsr_pkg::SET_W-1:0]  in_set,
	input  logic [clsr_pkg::WAY_W-1:0]  in_way,
	output logic [clsr_pkg::WAY_W-1:0]  res_way,
	output logic                        res_inv,
	output logic                        res_exh
);
	import clsr_pkg::*;

	// latched operation
	func_t              func_q;
	logic [SET_W-1:0]   set_q;
	logic [WAY_W-1:0]   way_q;

	// row memory and row-written flags
	row_t               row_mem_q [SET_COUNT];
	logic [SET_COUNT-1:0] row_init_q;
	row_t               rd_row_q;
	logic               rd_ok_q;
	row_t               row_eff;

	// access counter
	logic [STAMP_W-1:0] cnt_q;
	logic [STAMP_W-1:0] cnt_next;
	logic               cnt_max;

	// scan state
	logic [WAY_W-1:0]   scan_way_q;
	logic               inv_found_q;
	logic [WAY_W-1:0]   inv_way_q;
	logic [STAMP_W-1:0] best_q;
	logic [WAY_W-1:0]   best_way_q;
	logic               stale_found_q;
	logic [WAY_W-1:0]   stale_way_q;
	logic [STAMP_W-1:0] top_q;
	logic [WAY_W-1:0]   top_way_q;
	logic [STAMP_W-1:0] delta_q;
	logic [STAMP_W-1:0] cur_stamp;
	logic               cur_valid;

	// write port
	row_t               touch_row;
	row_t               age_row;
	logic               touch_we;
	logic               age_we;
	logic               wr_en;
	row_t               wr_row;

	// victim choice
	logic [WAY_W-1:0]   pick_way;
	logic               pick_inv;

	// results
	logic [WAY_W-1:0]   res_way_q;
	logic               res_inv_q;
	logic               res_exh_q;

	// latch the accepted operation
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func_t'(in_func);
			set_q  <= in_set;
			way_q  <= in_way;
		end
	end

	// a row never written reads as all zero
	assign row_eff   = rd_ok_q ? rd_row_q : '0;
	assign cnt_max   = &cnt_q;
	assign cnt_next  = cnt_q + STAMP_W'(1);
	assign cur_stamp = row_eff.stamp[scan_way_q];
	assign cur_valid = row_eff.valid[scan_way_q];

	// hit / fill update of the addressed way
	always_comb begin
		touch_row = row_eff;
		if (!cfg.srrip) begin
			touch_row.stamp[way_q] = cnt_next;
		end else if (func_q == FN_FILL) begin
			touch_row.stamp[way_q] = cfg.rrpv_fill;
		end else begin
			touch_row.stamp[way_q] = '0;
		end
		if (func_q == FN_FILL) begin
			touch_row.valid[way_q] = 1'b1;
		end
	end

	// age every way in use by the same amount
	always_comb begin
		age_row = row_eff;
		for (int w = 0; w < WAY_COUNT; w++) begin
			if (WAYS_N_W'(w) < cfg.ways) begin
				age_row.stamp[w] = row_eff.stamp[w] + delta_q;
			end
		end
	end

	assign touch_we = cmd.touch && !(!cfg.srrip && cnt_max);
	assign age_we   = cmd.wb && cfg.srrip && !inv_found_q && !stale_found_q;
	assign wr_en    = touch_we || age_we;
	assign wr_row   = touch_we ? touch_row : age_row;

	// row memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			row_mem_q[set_q] <= wr_row;
		end
		if (cmd.rd) begin
			rd_row_q <= row_mem_q[set_q];
		end
	end

	// row-written flags, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_init_q <= '0;
			rd_ok_q    <= 1'b0;
		end else begin
			if (wr_en) begin
				row_init_q[set_q] <= 1'b1;
			end
			if (cmd.rd) begin
				rd_ok_q <= row_init_q[set_q];
			end
		end
	end

	// advance the access counter on an LRU hit or fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.touch && !cfg.srrip && !cnt_max) begin
			cnt_q <= cnt_next;
		end
	end

	// scan one way per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_way_q    <= '0;
			inv_found_q   <= 1'b0;
			stale_found_q <= 1'b0;
		end else if (cmd.rd) begin
			scan_way_q    <= '0;
			inv_found_q   <= 1'b0;
			stale_found_q <= 1'b0;
		end else if (cmd.scan) begin
			scan_way_q <= scan_way_q + WAY_W'(1);
			if (!cur_valid && !inv_found_q) begin
				inv_found_q <= 1'b1;
			end
			if (cur_stamp >= cfg.rrpv_max) begin
				stale_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			top_q     <= '0;
			top_way_q <= '0;
		end else if (cmd.scan) begin
			if (!cur_valid && !inv_found_q) begin
				inv_way_q <= scan_way_q;
			end
			if (scan_way_q == '0 || cur_stamp < best_q) begin
				best_q     <= cur_stamp;
				best_way_q <= scan_way_q;
			end
			if (cur_stamp >= cfg.rrpv_max) begin
				stale_way_q <= scan_way_q;
			end
			if (cur_stamp >= top_q) begin
				top_q     <= cur_stamp;
				top_way_q <= scan_way_q;
			end
		end
		if (cmd.age) begin
			delta_q <= cfg.rrpv_max - top_q;
		end
	end

	// choose the victim from the scan results
	always_comb begin
		pick_inv = 1'b0;
		if (inv_found_q) begin
			pick_way = inv_way_q;
			pick_inv = 1'b1;
		end else if (!cfg.srrip) begin
			pick_way = best_way_q;
		end else if (stale_found_q) begin
			pick_way = stale_way_q;
		end else begin
			pick_way = top_way_q;
		end
	end

	// result fields
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			res_way_q <= '0;
			res_inv_q <= 1'b0;
			res_exh_q <= 1'b0;
		end else if (cmd.touch) begin
			res_exh_q <= !cfg.srrip && cnt_max;
		end else if (cmd.wb) begin
			res_way_q <= pick_way;
			res_inv_q <= pick_inv;
		end
	end

	assign res_way       = res_way_q;
	assign res_inv       = res_inv_q;
	assign res_exh       = res_exh_q;
	assign sts.func      = func_q;
	assign sts.scan_last = (WAYS_N_W'(scan_way_q) == cfg.ways - WAYS_N_W'(1));

`ifndef SYNTHESIS
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> (WAYS_N_W'(scan_way_q) < cfg.ways))
		else $error("scan stepped past the ways in use");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.touch && !cfg.srrip && !cnt_max) |=> (cnt_q == $past(cnt_next)))
		else $error("access counter did not advance by one");

	a_victim_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wb |=> (WAYS_N_W'(res_way_q) < $past(cfg.ways)))
		else $error("victim way outside the ways in use");
`endif

endmodule

FILE: hw/rtl/cache_lru_srrip_replacement.sv
// ----------------------------------------------------------------------------
// cache_lru_srrip_replacement: LRU / SRRIP replacement engine
// Top level: stream ports, configuration registers, output register, and the
// controller and datapath of the replacement engine.
// ----------------------------------------------------------------------------
// One operation (hit, fill or victim query) is taken at a time on the input
// stream and yields exactly one result on the result stream. A hit or fill
// goes through a row read from the set memory, update and write-back, and
// result hand-off. A victim query goes through the row read, a scan of the
// set's ways at one way per cycle, an aging step and a write-back. The
// output register lets a finished result wait on m_tready while the next
// operation is taken, but that operation holds in its last step until the
// register is free. The set memory needs no clearing pass: a per-set
// written flag, cleared at reset, makes an untouched set read as all
// invalid with zero stamps. Configuration writes are always accepted and
// must only be issued while the engine is idle.
module cache_lru_srrip_replacement (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [15:0]                     s_tdata,   // func[1:0], set_addr[7:2],
	                                                   // way_index[10:8]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [7:0]                      m_tdata,   // victim_way[2:0],
	                                                   // victim_was_invalid[3],
	                                                   // sequence_exhausted[4]
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [clsr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [clsr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import clsr_pkg::*;

	logic                  policy_q;
	logic [RRPV_CFG_W-1:0] rrpv_width_q;
	logic [WAYS_CFG_W-1:0] ways_cfg_q;
	cfg_t                  cfg_q;
	logic [5:0]            rrpv_shift;
	logic [STAMP_W-1:0]    rrpv_max;
	logic [WAYS_N_W-1:0]   ways_eff;

	cmd_t                  cmd;
	sts_t                  sts;
	logic                  res_load;
	logic                  out_free;
	logic [WAY_W-1:0]      res_way;
	logic                  res_inv;
	logic                  res_exh;
	logic                  m_tvalid_q;
	logic [7:0]            m_tdata_q;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q     <= 1'b0;
			rrpv_width_q <= RRPV_CFG_W'(2);
			ways_cfg_q   <= WAYS_CFG_W'(WAY_COUNT);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_POLICY:     policy_q     <= cfg_data[0];
				CFG_RRPV_WIDTH: rrpv_width_q <= cfg_data[RRPV_CFG_W-1:0];
				CFG_WAYS:       ways_cfg_q   <= cfg_data[WAYS_CFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// clamp width and way count, derive the RRPV limits
	always_comb begin
		rrpv_shift = (rrpv_width_q == '0) ? 6'd1 : rrpv_width_q[5:0];
		if (rrpv_width_q >= RRPV_CFG_W'(STAMP_W)) begin
			rrpv_max = '1;
		end else begin
			rrpv_max = (STAMP_W'(1) << rrpv_shift) - STAMP_W'(1);
		end
		if (ways_cfg_q == '0) begin
			ways_eff = WAYS_N_W'(1);
		end else if (ways_cfg_q > WAYS_CFG_W'(WAY_COUNT)) begin
			ways_eff = WAYS_N_W'(WAY_COUNT);
		end else begin
			ways_eff = WAYS_N_W'(ways_cfg_q);
		end
	end

	// hold the decoded configuration in registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else begin
			cfg_q.srrip     <= policy_q;
			cfg_q.rrpv_max  <= rrpv_max;
			cfg_q.rrpv_fill <= {rrpv_max[STAMP_W-1:1], 1'b0};
			cfg_q.ways      <= ways_eff;
		end
	end

	clsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.out_free (out_free),
		.cmd      (cmd),
		.res_load (res_load)
	);

	clsr_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.cfg     (cfg_q),
		.in_func (s_tdata[1:0]),
		.in_set  (s_tdata[7:2]),
		.in_way  (s_tdata[10:8]),
		.res_way (res_way),
		.res_inv (res_inv),
		.res_exh (res_exh)
	);

	// output register
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			m_tdata_q <= {3'b000, res_exh, res_inv, res_way};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
